### rtl/core/ries_pkg.sv
// shared types and constants for the region interpolated energy scaler
// no dependencies
package ries_pkg;

    localparam int MAX_REGIONS_DEF = 8;
    localparam int ENTRIES_PER_REGION_DEF = 64;

    localparam logic [1:0] OP_LOAD_WORD = 2'd0;
    localparam logic [1:0] OP_LOAD_BOUND = 2'd1;
    localparam logic [1:0] OP_SCALE = 2'd2;

    localparam logic [1:0] CFG_BIN_WIDTH = 2'd0;
    localparam logic [1:0] CFG_POINTS = 2'd1;
    localparam logic [1:0] CFG_BOUNDS = 2'd2;

    localparam logic [31:0] BIN_WIDTH_RST = 32'd65536;
    localparam logic [5:0] POINTS_RST = 6'd2;
    localparam logic [15:0] UNITY_Q14 = 16'h4000;

    typedef struct packed {
        logic        start;
        logic [31:0] rem_init;
        logic [31:0] num;
        logic [5:0]  steps;
    } ries_div_req_t;

    typedef struct packed {
        logic        word_en;
        logic        bound_en;
        logic [8:0]  addr;
        logic [15:0] value;
    } ries_wr_t;

endpackage

### rtl/core/ries_div.sv
// shared restoring divider, one quotient bit per cycle
// depends on ries_pkg
module ries_div
    import ries_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  ries_div_req_t req,
    input  logic [31:0]   den,
    output logic          done,
    output logic [31:0]   quot,
    output logic [31:0]   rem
);

    logic [31:0] rem_reg, rem_next;
    logic [31:0] num_reg, num_next;
    logic [31:0] quot_reg, quot_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        done_reg, done_next;
    logic [32:0] trial;
    logic        fits;

    always_comb
    begin
        rem_next = rem_reg;
        num_next = num_reg;
        quot_next = quot_reg;
        cnt_next = cnt_reg;
        done_next = 1'b0;
        trial = {rem_reg, num_reg[31]};
        fits = trial >= {1'b0, den};
        if (req.start)
        begin
            rem_next = req.rem_init;
            num_next = req.num;
            quot_next = '0;
            cnt_next = req.steps;
        end
        else if (cnt_reg != '0)
        begin
            rem_next = fits ? 32'(trial - {1'b0, den}) : trial[31:0];
            num_next = {num_reg[30:0], 1'b0};
            quot_next = {quot_reg[30:0], fits};
            cnt_next = cnt_reg - 6'd1;
            done_next = cnt_reg == 6'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        num_reg <= num_next;
        quot_reg <= quot_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;
    assign rem = rem_reg;

endmodule

### rtl/core/ries_store.sv
// correction word memory and theta boundary registers
// depends on ries_pkg
module ries_store
    import ries_pkg::*;
#(
    parameter int MAX_REGIONS = MAX_REGIONS_DEF,
    parameter int ENTRIES_PER_REGION = ENTRIES_PER_REGION_DEF,
    localparam int DEPTH = MAX_REGIONS * ENTRIES_PER_REGION,
    localparam int AW = $clog2(DEPTH),
    localparam int NBD = (MAX_REGIONS > 1) ? MAX_REGIONS - 1 : 1,
    localparam int BIW = (NBD > 1) ? $clog2(NBD) : 1
)
(
    input  logic           clk,
    input  ries_wr_t       wr,
    input  logic           rd_en,
    input  logic [AW-1:0]  rd_addr,
    output logic [15:0]    rd_data,
    input  logic [BIW-1:0] bnd_idx,
    output logic [15:0]    bnd_data
);

    logic [15:0] mem [DEPTH];
    logic [15:0] bnd_reg [NBD];
    logic [15:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.word_en && int'(wr.addr) < DEPTH)
        begin
            mem[AW'(wr.addr)] <= wr.value;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.bound_en && int'(wr.addr) < MAX_REGIONS - 1)
        begin
            bnd_reg[BIW'(wr.addr)] <= wr.value;
        end
    end

    assign rd_data = rd_data_reg;
    assign bnd_data = bnd_reg[bnd_idx];

endmodule

### rtl/core/region_interpolated_energy_scale_top.sv
// region interpolated energy scaler top: control sequencer and datapath
// depends on ries_pkg, ries_div, ries_store
// a scale request runs the region search, the bin division (32 divider steps), the table read
// and the multiply; interpolation adds a second read and a 16-step division; zero energy ends
// after the search, a zero bin width skips the bin division; loads stay idle, give no result
// one request at a time, the next is taken in the done cycle; the receiver cannot stall
// reset clears control and config; table contents are undefined until loaded
module region_interpolated_energy_scale_top
    import ries_pkg::*;
#(
    parameter int MAX_REGIONS = MAX_REGIONS_DEF,
    parameter int ENTRIES_PER_REGION = ENTRIES_PER_REGION_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  opcode,
    input  logic [8:0]  table_address,
    input  logic [15:0] load_value,
    input  logic [31:0] energy,
    input  logic [15:0] theta,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output logic        done,
    output logic [31:0] scaled_energy,
    output logic [15:0] factor_used,
    output logic [2:0]  region_found,
    output logic        clipped
);

    localparam int DEPTH = MAX_REGIONS * ENTRIES_PER_REGION;
    localparam int AW = $clog2(DEPTH);
    localparam int RW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int EW = $clog2(ENTRIES_PER_REGION);
    localparam int NBD = (MAX_REGIONS > 1) ? MAX_REGIONS - 1 : 1;
    localparam int BIW = (NBD > 1) ? $clog2(NBD) : 1;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_SRCH = 4'd1;
    localparam logic [3:0] S_BIN = 4'd2;
    localparam logic [3:0] S_RD0 = 4'd3;
    localparam logic [3:0] S_RD1 = 4'd4;
    localparam logic [3:0] S_RD2 = 4'd5;
    localparam logic [3:0] S_MAG = 4'd6;
    localparam logic [3:0] S_QST = 4'd7;
    localparam logic [3:0] S_QDIV = 4'd8;
    localparam logic [3:0] S_MULF = 4'd9;
    localparam logic [3:0] S_OUT = 4'd10;

    logic [3:0]    state_reg, state_next;
    logic [31:0]   width_reg, width_next;
    logic [5:0]    points_reg, points_next;
    logic [2:0]    bcount_reg, bcount_next;
    logic [31:0]   energy_reg, energy_next;
    logic [15:0]   theta_reg, theta_next;
    logic [RW-1:0] idx_reg, idx_next;
    logic [RW-1:0] region_reg, region_next;
    logic [EW-1:0] entry_reg, entry_next;
    logic          interp_reg, interp_next;
    logic [31:0]   rem_reg, rem_next;
    logic [15:0]   lo_reg, lo_next;
    logic [15:0]   mag_reg, mag_next;
    logic          neg_reg, neg_next;
    logic [47:0]   prod_reg, prod_next;
    logic [15:0]   factor_reg, factor_next;
    logic          done_reg, done_next;
    logic [31:0]   scaled_reg, scaled_next;
    logic          clip_reg, clip_next;

    logic [EW:0]   pts;
    logic [RW-1:0] nb;
    logic [31:0]   bin_last;
    logic [33:0]   shifted;
    ries_div_req_t div_req;
    logic          div_done;
    logic [31:0]   div_quot;
    logic [31:0]   div_rem;
    ries_wr_t      wr;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [15:0]   rd_data;
    logic [15:0]   bnd_data;

    ries_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .den   (width_reg),
        .done  (div_done),
        .quot  (div_quot),
        .rem   (div_rem)
    );

    ries_store #(
        .MAX_REGIONS        (MAX_REGIONS),
        .ENTRIES_PER_REGION (ENTRIES_PER_REGION)
    ) u_store (
        .clk      (clk),
        .wr       (wr),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data),
        .bnd_idx  (BIW'(idx_reg)),
        .bnd_data (bnd_data)
    );

    always_comb
    begin
        if (int'(points_reg) < 2)
            pts = (EW+1)'(2);
        else if (int'(points_reg) > ENTRIES_PER_REGION - 2)
            pts = (EW+1)'(ENTRIES_PER_REGION - 2);
        else
            pts = (EW+1)'(points_reg);
        if (int'(bcount_reg) > MAX_REGIONS - 1)
            nb = RW'(MAX_REGIONS - 1);
        else
            nb = RW'(bcount_reg);
        bin_last = 32'(pts) - 32'd1;
    end

    assign shifted = prod_reg[47:14];

    always_comb
    begin
        state_next = state_reg;
        width_next = width_reg;
        points_next = points_reg;
        bcount_next = bcount_reg;
        energy_next = energy_reg;
        theta_next = theta_reg;
        idx_next = idx_reg;
        region_next = region_reg;
        entry_next = entry_reg;
        interp_next = interp_reg;
        rem_next = rem_reg;
        lo_next = lo_reg;
        mag_next = mag_reg;
        neg_next = neg_reg;
        prod_next = prod_reg;
        factor_next = factor_reg;
        done_next = 1'b0;
        scaled_next = scaled_reg;
        clip_next = clip_reg;
        div_req = '0;
        wr = '0;
        rd_en = 1'b0;
        rd_addr = AW'(int'(region_reg) * ENTRIES_PER_REGION + int'(entry_reg));

        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_BIN_WIDTH: width_next = cfg_data;
                CFG_POINTS:    points_next = cfg_data[5:0];
                CFG_BOUNDS:    bcount_next = cfg_data[2:0];
                default:       ;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    wr.addr = table_address;
                    wr.value = load_value;
                    wr.word_en = opcode == OP_LOAD_WORD;
                    wr.bound_en = opcode == OP_LOAD_BOUND;
                    if (opcode == OP_SCALE)
                    begin
                        energy_next = energy;
                        theta_next = theta;
                        idx_next = '0;
                        state_next = S_SRCH;
                    end
                end
            end
            S_SRCH:
            begin
                if (idx_reg == nb || theta_reg < bnd_data)
                begin
                    region_next = idx_reg;
                    if (energy_reg == '0)
                    begin
                        scaled_next = '0;
                        factor_next = UNITY_Q14;
                        clip_next = 1'b0;
                        done_next = 1'b1;
                        state_next = S_IDLE;
                    end
                    else if (width_reg == '0)
                    begin
                        entry_next = EW'(pts + 1'b1);
                        interp_next = 1'b0;
                        state_next = S_RD0;
                    end
                    else
                    begin
                        div_req.start = 1'b1;
                        div_req.rem_init = '0;
                        div_req.num = energy_reg;
                        div_req.steps = 6'd32;
                        state_next = S_BIN;
                    end
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_BIN:
            begin
                if (div_done)
                begin
                    rem_next = div_rem;
                    if (div_quot == '0)
                    begin
                        entry_next = '0;
                        interp_next = 1'b0;
                    end
                    else if (div_quot < bin_last)
                    begin
                        entry_next = EW'(div_quot);
                        interp_next = 1'b1;
                    end
                    else
                    begin
                        entry_next = EW'(pts + 1'b1);
                        interp_next = 1'b0;
                    end
                    state_next = S_RD0;
                end
            end
            S_RD0:
            begin
                rd_en = 1'b1;
                state_next = S_RD1;
            end
            S_RD1:
            begin
                lo_next = rd_data;
                if (interp_reg)
                begin
                    rd_en = 1'b1;
                    rd_addr = AW'(int'(region_reg) * ENTRIES_PER_REGION
                                  + int'(entry_reg) + 1);
                    state_next = S_RD2;
                end
                else
                begin
                    factor_next = rd_data;
                    state_next = S_MULF;
                end
            end
            S_RD2:
            begin
                neg_next = rd_data < lo_reg;
                mag_next = (rd_data < lo_reg) ? lo_reg - rd_data : rd_data - lo_reg;
                state_next = S_MAG;
            end
            S_MAG:
            begin
                prod_next = 48'(rem_reg) * 48'(mag_reg);
                state_next = S_QST;
            end
            S_QST:
            begin
                div_req.start = 1'b1;
                div_req.rem_init = prod_reg[47:16];
                div_req.num = {prod_reg[15:0], 16'd0};
                div_req.steps = 6'd16;
                state_next = S_QDIV;
            end
            S_QDIV:
            begin
                if (div_done)
                begin
                    factor_next = neg_reg ? lo_reg - div_quot[15:0]
                                          : lo_reg + div_quot[15:0];
                    state_next = S_MULF;
                end
            end
            S_MULF:
            begin
                prod_next = 48'(energy_reg) * 48'(factor_reg);
                state_next = S_OUT;
            end
            S_OUT:
            begin
                clip_next = |shifted[33:32];
                scaled_next = (|shifted[33:32]) ? '1 : shifted[31:0];
                done_next = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            width_reg <= BIN_WIDTH_RST;
            points_reg <= POINTS_RST;
            bcount_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            width_reg <= width_next;
            points_reg <= points_next;
            bcount_reg <= bcount_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        energy_reg <= energy_next;
        theta_reg <= theta_next;
        idx_reg <= idx_next;
        region_reg <= region_next;
        entry_reg <= entry_next;
        interp_reg <= interp_next;
        rem_reg <= rem_next;
        lo_reg <= lo_next;
        mag_reg <= mag_next;
        neg_reg <= neg_next;
        prod_reg <= prod_next;
        factor_reg <= factor_next;
        scaled_reg <= scaled_next;
        clip_reg <= clip_next;
    end

    assign busy = state_reg != S_IDLE;
    assign cfg_ready = 1'b1;
    assign done = done_reg;
    assign scaled_energy = scaled_reg;
    assign factor_used = factor_reg;
    assign region_found = 3'(region_reg);
    assign clipped = clip_reg;

endmodule

### rtl/core/ries_checker.sv
// port level checks for the region interpolated energy scaler
// depends on ries_pkg; bound to region_interpolated_energy_scale_top
module ries_checker
    import ries_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic [1:0]  opcode,
    input logic        done,
    input logic [31:0] scaled_energy,
    input logic        clipped
);

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy) else $error("result while busy");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("result repeated");

    a_clip_sat: assert property (@(posedge clk) disable iff (!rst_n)
        done && clipped |-> scaled_energy == 32'hFFFF_FFFF)
        else $error("clip without saturation");

    a_load_quick: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && opcode != OP_SCALE |=> !busy && !done)
        else $error("load request held the block");

    a_scale_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && opcode == OP_SCALE |=> busy)
        else $error("scale request not taken");

endmodule

bind region_interpolated_energy_scale_top ries_checker u_ries_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .opcode        (opcode),
    .done          (done),
    .scaled_energy (scaled_energy),
    .clipped       (clipped)
);

### tb/tb_region_interpolated_energy_scale_top.sv
// self-checking testbench for region_interpolated_energy_scale_top
// depends on ries_pkg and the block's rtl; runs table loads, config phases, scale requests
`timescale 1ns / 100ps

module tb_region_interpolated_energy_scale_top;
    import ries_pkg::*;

    localparam logic [1:0] OP_UNKNOWN = 2'd3;
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    typedef struct {
        logic [1:0]  op;
        logic [8:0]  addr;
        logic [15:0] val;
        logic [31:0] en;
        logic [15:0] th;
    } scale_req_t;

    typedef struct {
        logic [31:0] scaled;
        logic [15:0] factor;
        logic [2:0]  region;
        logic        clip;
    } scale_res_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  opcode = '0;
    logic [8:0]  table_address = '0;
    logic [15:0] load_value = '0;
    logic [31:0] energy = '0;
    logic [15:0] theta = '0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic        done;
    logic [31:0] scaled_energy;
    logic [15:0] factor_used;
    logic [2:0]  region_found;
    logic        clipped;

    region_interpolated_energy_scale_top dut (.*);

    always #4 clk = ~clk;

    scale_req_t  pend_q[$];
    scale_res_t  expected_q[$];
    scale_req_t  cur_req;

    // model state seen at acceptance
    logic [15:0] corr_tab [512];
    logic [15:0] bound_tab [7];
    logic [31:0] bin_width = BIN_WIDTH_RST;
    logic [5:0]  points = POINTS_RST;
    logic [2:0]  bound_cnt = '0;

    // generator shadows, ahead of acceptance but in the same order
    bit          gen_written [512];
    logic [15:0] gen_bound [7];

    int errors = 0;
    int checked = 0;
    int n_scale = 0;
    int n_load = 0;
    int gap = 0;
    bit quiet = 1'b0;

    function automatic int unsigned find_region(logic [15:0] th, logic [15:0] bt [7],
                                                 logic [2:0] cnt);
        int unsigned n;
        n = (cnt > 7) ? 7 : cnt;
        for (int i = 0; i < n; i++)
            if (th < bt[i])
                return i;
        return n;
    endfunction

    function automatic int unsigned clamp_points(logic [5:0] p);
        if (p < 2)
            return 2;
        if (p > 62)
            return 62;
        return p;
    endfunction

    // entry indexes within the region that a scale request will read
    function automatic void needed_entries(logic [31:0] e, logic [31:0] w, logic [5:0] p,
                                           output int lo_e, output int hi_e);
        logic [31:0] b;
        int unsigned pts;
        pts = clamp_points(p);
        b = (w == 0) ? 32'hFFFF_FFFF : e / w;
        lo_e = -1;
        hi_e = -1;
        if (e == 0)
            return;
        if (b == 0)
            lo_e = 0;
        else if (b < pts - 1)
        begin
            lo_e = b;
            hi_e = b + 1;
        end
        else
            lo_e = pts + 1;
    endfunction

    function automatic logic [15:0] interp_factor(int unsigned reg_i, logic [31:0] e);
        logic [31:0] b, rem, w, q;
        logic [15:0] lo, hi;
        logic [63:0] prod;
        int unsigned pts;
        pts = clamp_points(points);
        w = bin_width;
        if (w == 0)
        begin
            b = 32'hFFFF_FFFF;
            rem = 0;
        end
        else
        begin
            b = e / w;
            rem = e - b * w;
        end
        if (b == 0)
            return corr_tab[reg_i * 64];
        if (b < pts - 1)
        begin
            lo = corr_tab[reg_i * 64 + b];
            hi = corr_tab[reg_i * 64 + b + 1];
            if (hi >= lo)
            begin
                prod = 64'(rem) * 64'(hi - lo);
                q = 32'(prod / 64'(w));
                return 16'(32'(lo) + q);
            end
            prod = 64'(rem) * 64'(lo - hi);
            q = 32'(prod / 64'(w));
            return 16'(32'(lo) - q);
        end
        return corr_tab[reg_i * 64 + pts + 1];
    endfunction

    task automatic apply_request(scale_req_t r);
        scale_res_t x;
        int unsigned rg;
        logic [63:0] prod;
        if (r.op == OP_LOAD_WORD)
        begin
            corr_tab[r.addr] = r.val;
            n_load++;
        end
        else if (r.op == OP_LOAD_BOUND)
        begin
            if (r.addr < 7)
                bound_tab[r.addr] = r.val;
            n_load++;
        end
        else if (r.op == OP_SCALE)
        begin
            n_scale++;
            rg = find_region(r.th, bound_tab, bound_cnt);
            x.region = 3'(rg);
            if (r.en == 0)
            begin
                x.scaled = 0;
                x.factor = UNITY_Q14;
                x.clip = 1'b0;
            end
            else
            begin
                x.factor = interp_factor(rg, r.en);
                prod = (64'(r.en) * 64'(x.factor)) >> 14;
                x.clip = prod > 64'hFFFF_FFFF;
                x.scaled = x.clip ? 32'hFFFF_FFFF : prod[31:0];
            end
            expected_q = {expected_q, x};
        end
    endtask

    function automatic void push_load_word(logic [8:0] a, logic [15:0] v);
        scale_req_t r;
        r.op = OP_LOAD_WORD;
        r.addr = a;
        r.val = v;
        r.en = $urandom;
        r.th = 16'($urandom);
        gen_written[a] = 1'b1;
        pend_q = {pend_q, r};
    endfunction

    function automatic void push_load_bound(logic [8:0] a, logic [15:0] v);
        scale_req_t r;
        r.op = OP_LOAD_BOUND;
        r.addr = a;
        r.val = v;
        r.en = $urandom;
        r.th = 16'($urandom);
        if (a < 7)
            gen_bound[a] = v;
        pend_q = {pend_q, r};
    endfunction

    // queue a scale request, loading any table word it reads that is still unwritten
    function automatic void push_scale(logic [31:0] e, logic [15:0] th);
        scale_req_t r;
        int unsigned rg;
        int lo_e, hi_e;
        rg = find_region(th, gen_bound, bound_cnt);
        needed_entries(e, bin_width, points, lo_e, hi_e);
        if (lo_e >= 0 && !gen_written[rg * 64 + lo_e])
            push_load_word(9'(rg * 64 + lo_e), 16'($urandom));
        if (hi_e >= 0 && !gen_written[rg * 64 + hi_e])
            push_load_word(9'(rg * 64 + hi_e), 16'($urandom));
        r.op = OP_SCALE;
        r.addr = 9'($urandom);
        r.val = 16'($urandom);
        r.en = e;
        r.th = th;
        pend_q = {pend_q, r};
    endfunction

    function automatic logic [31:0] pick_energy();
        logic [63:0] e64;
        int unsigned b;
        case ($urandom_range(0, 9))
            0: return 0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom;
            default:
            begin
                if (bin_width == 0)
                    return $urandom;
                b = $urandom_range(0, clamp_points(points) + 2);
                e64 = 64'(b) * 64'(bin_width) + 64'($urandom_range(0, bin_width - 1));
                return (e64 > 64'hFFFF_FFFF) ? $urandom : e64[31:0];
            end
        endcase
    endfunction

    function automatic logic [15:0] pick_theta();
        int unsigned k;
        k = $urandom_range(0, 6);
        case ($urandom_range(0, 3))
            0: return gen_bound[k];
            1: return gen_bound[k] - 16'd1;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic void fill_random(int count);
        scale_req_t r;
        int unsigned sel;
        for (int i = 0; i < count; i++)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 20)
                push_load_word(9'($urandom), 16'($urandom));
            else if (sel < 25)
                push_load_bound(9'($urandom_range(0, 15)), 16'($urandom));
            else if (sel < 28)
            begin
                r.op = OP_UNKNOWN;
                r.addr = 9'($urandom);
                r.val = 16'($urandom);
                r.en = $urandom;
                r.th = 16'($urandom);
                pend_q = {pend_q, r};
            end
            else
                push_scale(pick_energy(), pick_theta());
        end
    endfunction

    task automatic cfg_write(logic [1:0] idx, logic [31:0] d);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_BIN_WIDTH: bin_width = d;
            CFG_POINTS:    points = d[5:0];
            CFG_BOUNDS:    bound_cnt = d[2:0];
            default:       ;
        endcase
    endtask

    task automatic wait_drained();
        @(posedge clk);
        while (pend_q.size() != 0 || start || expected_q.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    // request driver
    always @(posedge clk)
    begin
        logic nxt;
        nxt = start;
        if (start && !busy)
        begin
            apply_request(cur_req);
            nxt = 1'b0;
        end
        if (!nxt && rst_n)
        begin
            if (gap > 0)
                gap--;
            else if (!quiet && $urandom_range(0, 5) == 0)
                gap = $urandom_range(1, 14);
            else if (pend_q.size() != 0)
            begin
                cur_req = pend_q.pop_front();
                opcode <= cur_req.op;
                table_address <= cur_req.addr;
                load_value <= cur_req.val;
                energy <= cur_req.en;
                theta <= cur_req.th;
                nxt = 1'b1;
            end
        end
        start <= nxt;
    end

    // result monitor
    always @(posedge clk)
    begin
        scale_res_t x;
        if (rst_n && done)
        begin
            if (expected_q.size() == 0)
            begin
                $display("%0t: result with none expected: scaled %h factor %h region %0d",
                         $time, scaled_energy, factor_used, region_found);
                errors++;
            end
            else
            begin
                x = expected_q.pop_front();
                checked++;
                if (scaled_energy !== x.scaled)
                begin
                    $display("%0t: scaled_energy expected %h actual %h", $time, x.scaled,
                             scaled_energy);
                    errors++;
                end
                if (factor_used !== x.factor)
                begin
                    $display("%0t: factor_used expected %h actual %h", $time, x.factor,
                             factor_used);
                    errors++;
                end
                if (region_found !== x.region)
                begin
                    $display("%0t: region_found expected %0d actual %0d", $time, x.region,
                             region_found);
                    errors++;
                end
                if (clipped !== x.clip)
                begin
                    $display("%0t: clipped expected %b actual %b", $time, x.clip, clipped);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        #5ms;
        $display("FAIL");
        $finish;
    end

    initial
    begin
        logic [31:0] widths [7] = '{1000, 1, 32'hFFFF_FFFF, 0, 300, 77, 4096};
        logic [5:0]  pts    [7] = '{8, 62, 5, 4, 0, 63, 16};
        logic [2:0]  bcs    [7] = '{3, 7, 2, 1, 5, 4, 6};
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // directed: defaults, ignored loads, unknown opcode, field extremes
        for (int i = 0; i < 7; i++)
            push_load_bound(9'(i), 16'(i * 9000 + 5000));
        push_load_bound(9'd7, 16'hFFFF);
        push_load_bound(9'd511, 16'h0);
        push_load_word(9'd0, 16'hFFFF);
        push_load_word(9'd511, 16'h0);
        push_scale(0, 0);
        push_scale(32'hFFFF_FFFF, 16'hFFFF);
        push_scale(1, 16'hFFFF);
        push_scale(32'd65536, 0);
        push_scale(32'd200000, 16'd100);
        begin
            scale_req_t r;
            r.op = OP_UNKNOWN;
            r.addr = 9'h1FF;
            r.val = 16'hFFFF;
            r.en = 32'hFFFF_FFFF;
            r.th = 16'hFFFF;
            pend_q = {pend_q, r};
        end
        fill_random(60);
        wait_drained();
        cfg_write(CFG_UNUSED, 32'hFFFF_FFFF);

        for (int ph = 0; ph < 7; ph++)
        begin
            cfg_write(CFG_BIN_WIDTH, widths[ph]);
            cfg_write(CFG_POINTS, {26'h3FF_FFFF, pts[ph]});
            cfg_write(CFG_BOUNDS, {29'h1FFF_FFFF, bcs[ph]});
            quiet = (ph == 6);
            for (int i = 0; i < 7; i++)
                push_load_bound(9'(i), 16'($urandom));
            fill_random(75);
            wait_drained();
        end

        $display("covered %0d scale requests and %0d table loads over 8 config settings,",
                 n_scale, n_load);
        $display("%0d results checked field by field", checked);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

### files.f
rtl/core/ries_pkg.sv
rtl/core/ries_div.sv
rtl/core/ries_store.sv
rtl/core/region_interpolated_energy_scale_top.sv
rtl/core/ries_checker.sv
tb/tb_region_interpolated_energy_scale_top.sv
